### hw/rtl/pcxrle_pkg.sv
// Package for the PCX scanline run-length decoder.
// Holds the transfer payload types, the configuration types and the shared constants.
// Depends on nothing.
package pcxrle_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd5;

    localparam logic [7:0] MARKER_MIN  = 8'hC0;
    localparam logic [5:0] RUN_MASK    = 6'h3F;
    localparam logic [5:0] LITERAL_RUN = 6'd1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_group;
        logic [3:0]  pixel_count;
        logic [13:0] first_x;
        logic [15:0] line_index;
        logic        end_of_line;
        logic        end_of_image;
    } t_out_item;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] run;
    } t_cmd;

    typedef struct packed {
        logic        compressed;
        logic [2:0]  plane_count;
        logic [3:0]  pixel_depth;
        logic [11:0] bytes_per_plane_line;
        logic [14:0] image_width;
        logic [16:0] image_height;
    } t_cfg;

endpackage

### hw/rtl/pcxrle_front.sv
// Front end of the PCX decoder: accepts stream bytes and classifies them.
// Markers are held here; literals and runs go to the command queue as value and length.
// Depends on pcxrle_pkg.
module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_compressed,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic       r_pend;
    logic       n_pend;
    logic [5:0] r_prun;
    logic [5:0] n_prun;
    logic       w_accept;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        n_pend      = r_pend;
        n_prun      = r_prun;
        o_push      = 1'b0;
        o_cmd.value = i_in_data.stream_byte;
        o_cmd.run   = LITERAL_RUN;
        if (w_accept) begin
            if (i_compressed) begin
                if (r_pend) begin
                    n_pend    = 1'b0;
                    n_prun    = '0;
                    o_cmd.run = r_prun;
                    o_push    = (r_prun != 6'd0);
                end else if (i_in_data.stream_byte >= MARKER_MIN && !i_in_data.final_byte) begin
                    n_pend = 1'b1;
                    n_prun = i_in_data.stream_byte[5:0] & RUN_MASK;
                end else begin
                    o_push = 1'b1;
                end
            end else begin
                n_pend = 1'b0;
                n_prun = '0;
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_prun <= '0;
        end else begin
            r_pend <= n_pend;
            r_prun <= n_prun;
        end
    end

endmodule

### hw/rtl/pcxrle_queue.sv
// Short command queue between the front and back ends of the PCX decoder.
// Depends on pcxrle_pkg for the command type and the queue depth.
module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic [QP_W-1:0] w_wr_next;
    logic [QP_W-1:0] w_rd_next;

    assign o_full    = (r_count == (QP_W+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_wr_next = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= w_wr_next;
            end
            if (i_pop) begin
                r_rd_ptr <= w_rd_next;
            end
            case ({i_push, i_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

### hw/rtl/pcxrle_back.sv
// Back end of the PCX decoder: expands queued runs into the line store and assembles pixels.
// Holds the line store memory, the line position and counters, and the output register.
// Depends on pcxrle_pkg.
module pcxrle_back
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 8192
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_cmd      i_q_data,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int POS_W = $clog2(MAX_LINE_BYTES);
    localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int AW    = (LEN_W > 15) ? LEN_W : 15;
    localparam int XW    = AW + 3;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_STORE = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_CAPT  = 3'd3;
    localparam logic [2:0] B_EMIT  = 3'd4;

    localparam logic [2:0] FMT_NONE   = 3'd0;
    localparam logic [2:0] FMT_RGB    = 3'd1;
    localparam logic [2:0] FMT_IDX8   = 3'd2;
    localparam logic [2:0] FMT_PACK   = 3'd3;
    localparam logic [2:0] FMT_PLANAR = 3'd4;

    logic [7:0]       r_store [MAX_LINE_BYTES];
    logic [7:0]       r_rd_data;
    logic [7:0]       r_plane [3];

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [5:0]       r_run;
    logic [5:0]       n_run;
    logic [7:0]       r_val;
    logic [7:0]       n_val;
    logic [15:0]      r_line;
    logic [15:0]      n_line;
    logic             r_done;
    logic             n_done;
    logic [POS_W-1:0] r_rd_addr;
    logic [POS_W-1:0] n_rd_addr;
    logic [1:0]       r_rd_idx;
    logic [1:0]       n_rd_idx;
    logic [13:0]      r_x0;
    logic [13:0]      n_x0;
    logic [3:0]       r_cnt;
    logic [3:0]       n_cnt;
    logic             r_eol;
    logic             n_eol;
    logic             r_eoi;
    logic             n_eoi;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             w_we;
    logic             w_cap;
    logic             w_adv;
    logic             w_out_free;
    logic [2:0]       w_pc;
    logic [3:0]       w_bpp;
    logic [11:0]      w_bpl;
    logic [14:0]      w_prod;
    logic [14:0]      w_base;
    logic [AW-1:0]    w_len;
    logic [14:0]      w_width;
    logic [16:0]      w_height;
    logic             w_last_line;
    logic [AW-1:0]    w_pos_ext;
    logic [AW-1:0]    w_pos1;
    logic             w_end_after;
    logic             w_base_ok;
    logic [AW-1:0]    w_k;
    logic [2:0]       w_fmt;
    logic [XW-1:0]    w_x0;
    logic [3:0]       w_ppb;
    logic [XW-1:0]    w_rem;
    logic             w_eligible;
    logic             w_needs_read;
    logic [1:0]       w_last_idx;
    logic [7:0]       w_pl0;
    logic [7:0]       w_pl1;
    logic [7:0]       w_pl2;
    logic [7:0]       w_pl3;
    logic [31:0]      w_group;

    assign w_pc  = i_cfg.plane_count;
    assign w_bpp = i_cfg.pixel_depth;
    assign w_bpl = i_cfg.bytes_per_plane_line;

    assign w_prod = {12'd0, w_pc} * {3'd0, w_bpl};
    assign w_base = {12'd0, w_pc - 3'd1} * {3'd0, w_bpl};
    assign w_len  = (AW'(w_prod) > AW'(MAX_LINE_BYTES)) ? AW'(MAX_LINE_BYTES) : AW'(w_prod);

    assign w_width  = (i_cfg.image_width > 15'd16384) ? 15'd16384 : i_cfg.image_width;
    assign w_height = (i_cfg.image_height == 17'd0) ? 17'd1 :
                      (i_cfg.image_height > 17'd65536) ? 17'd65536 : i_cfg.image_height;
    assign w_last_line = (({1'b0, r_line} + 17'd1) >= w_height);

    assign w_pos_ext   = AW'(r_pos);
    assign w_pos1      = w_pos_ext + 1'b1;
    assign w_end_after = (w_pos1 >= w_len);
    assign w_base_ok   = (w_pos_ext >= AW'(w_base));
    assign w_k         = w_pos_ext - AW'(w_base);
    assign w_last_idx  = 2'(w_pc - 3'd2);

    always_comb begin
        if (w_pc == 3'd3 && w_bpp == 4'd8) begin
            w_fmt = FMT_RGB;
        end else if (w_pc == 3'd1 && w_bpp == 4'd8) begin
            w_fmt = FMT_IDX8;
        end else if (w_pc == 3'd1 && (w_bpp == 4'd1 || w_bpp == 4'd2 || w_bpp == 4'd4)) begin
            w_fmt = FMT_PACK;
        end else if (w_bpp == 4'd1 && w_pc >= 3'd2 && w_pc <= 3'd4) begin
            w_fmt = FMT_PLANAR;
        end else begin
            w_fmt = FMT_NONE;
        end
    end

    always_comb begin
        w_x0         = '0;
        w_ppb        = 4'd1;
        w_eligible   = 1'b0;
        w_needs_read = 1'b0;
        case (w_fmt)
            FMT_RGB: begin
                w_x0         = XW'(w_k);
                w_eligible   = w_base_ok;
                w_needs_read = 1'b1;
            end
            FMT_IDX8: begin
                w_x0       = XW'(w_pos_ext);
                w_eligible = 1'b1;
            end
            FMT_PACK: begin
                w_eligible = 1'b1;
                case (w_bpp)
                    4'd1: begin
                        w_x0  = XW'(w_pos_ext) << 3;
                        w_ppb = 4'd8;
                    end
                    4'd2: begin
                        w_x0  = XW'(w_pos_ext) << 2;
                        w_ppb = 4'd4;
                    end
                    default: begin
                        w_x0  = XW'(w_pos_ext) << 1;
                        w_ppb = 4'd2;
                    end
                endcase
            end
            FMT_PLANAR: begin
                w_x0         = XW'(w_k) << 3;
                w_ppb        = 4'd8;
                w_eligible   = w_base_ok;
                w_needs_read = 1'b1;
            end
            default: begin
                w_eligible = 1'b0;
            end
        endcase
        if (w_x0 >= XW'(w_width)) begin
            w_eligible = 1'b0;
        end
    end

    assign w_rem = XW'(w_width) - w_x0;

    always_comb begin
        w_pl0 = r_plane[0];
        w_pl1 = (w_pc == 3'd2) ? r_val : r_plane[1];
        w_pl2 = (w_pc == 3'd3) ? r_val : ((w_pc == 3'd4) ? r_plane[2] : 8'd0);
        w_pl3 = (w_pc == 3'd4) ? r_val : 8'd0;
    end

    always_comb begin
        w_group = '0;
        case (w_fmt)
            FMT_RGB: begin
                w_group = {8'd0, r_plane[0], r_plane[1], r_val};
            end
            FMT_IDX8: begin
                w_group = {24'd0, r_val};
            end
            FMT_PACK: begin
                if (w_bpp == 4'd1) begin
                    for (int j = 0; j < 8; j++) begin
                        if (4'(j) < r_cnt) begin
                            w_group[4*j +: 4] = {3'd0, r_val[7-j]};
                        end
                    end
                end else if (w_bpp == 4'd2) begin
                    for (int j = 0; j < 4; j++) begin
                        if (4'(j) < r_cnt) begin
                            w_group[4*j +: 4] = {2'd0, r_val[7-2*j -: 2]};
                        end
                    end
                end else begin
                    for (int j = 0; j < 2; j++) begin
                        if (4'(j) < r_cnt) begin
                            w_group[4*j +: 4] = r_val[7-4*j -: 4];
                        end
                    end
                end
            end
            FMT_PLANAR: begin
                for (int j = 0; j < 8; j++) begin
                    if (4'(j) < r_cnt) begin
                        w_group[4*j +: 4] = {w_pl3[7-j], w_pl2[7-j], w_pl1[7-j], w_pl0[7-j]};
                    end
                end
            end
            default: begin
                w_group = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_run       = r_run;
        n_val       = r_val;
        n_line      = r_line;
        n_done      = r_done;
        n_rd_addr   = r_rd_addr;
        n_rd_idx    = r_rd_idx;
        n_x0        = r_x0;
        n_cnt       = r_cnt;
        n_eol       = r_eol;
        n_eoi       = r_eoi;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_cap       = 1'b0;
        w_adv       = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_val = i_q_data.value;
                    n_run = i_q_data.run;
                    if (i_q_data.run != 6'd0) begin
                        n_state = B_STORE;
                    end
                end
            end
            B_STORE: begin
                if (r_done || w_len == '0) begin
                    n_state = B_IDLE;
                end else if (w_pos_ext >= w_len) begin
                    // The geometry shrank under the current position: close the line first.
                    n_pos = '0;
                    if (w_last_line) begin
                        n_done = 1'b1;
                    end else begin
                        n_line = r_line + 1'b1;
                    end
                end else begin
                    w_we = 1'b1;
                    if (w_eligible) begin
                        n_x0  = w_x0[13:0];
                        n_cnt = (w_rem < XW'(w_ppb)) ? w_rem[3:0] : w_ppb;
                        n_eol = (w_rem <= XW'(w_ppb));
                        n_eoi = (w_rem <= XW'(w_ppb)) && w_last_line;
                        if (w_needs_read) begin
                            n_rd_addr = POS_W'(w_k);
                            n_rd_idx  = '0;
                            n_state   = B_READ;
                        end else begin
                            n_state = B_EMIT;
                        end
                    end else begin
                        w_adv = 1'b1;
                    end
                end
            end
            B_READ: begin
                n_state = B_CAPT;
            end
            B_CAPT: begin
                w_cap     = 1'b1;
                n_rd_addr = POS_W'(AW'(r_rd_addr) + AW'(w_bpl));
                n_rd_idx  = r_rd_idx + 1'b1;
                if (r_rd_idx == w_last_idx) begin
                    n_state = B_EMIT;
                end else begin
                    n_state = B_READ;
                end
            end
            B_EMIT: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.pixel_group = w_group;
                    n_out.pixel_count = r_cnt;
                    n_out.first_x     = r_x0;
                    n_out.line_index  = r_line;
                    n_out.end_of_line = r_eol;
                    n_out.end_of_image = r_eoi;
                    w_adv             = 1'b1;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        if (w_adv) begin
            if (w_end_after) begin
                n_pos   = '0;
                n_state = B_IDLE;
                if (w_last_line) begin
                    n_done = 1'b1;
                end else begin
                    n_line = r_line + 1'b1;
                end
            end else begin
                n_pos = POS_W'(w_pos1);
                if (r_run == 6'd1) begin
                    n_state = B_IDLE;
                end else begin
                    n_run   = r_run - 1'b1;
                    n_state = B_STORE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_pos] <= r_val;
        end
        r_rd_data <= r_store[r_rd_addr];
        if (w_cap) begin
            r_plane[r_rd_idx] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_rd_addr <= n_rd_addr;
        r_x0      <= n_x0;
        r_cnt     <= n_cnt;
        r_eol     <= n_eol;
        r_eoi     <= n_eoi;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pos       <= '0;
            r_run       <= '0;
            r_line      <= '0;
            r_done      <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_run       <= n_run;
            r_line      <= n_line;
            r_done      <= n_done;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/pcx_scanline_rle_decoder.sv
// Top level of the PCX scanline run-length decoder; uses pcxrle_pkg, pcxrle_front,
// pcxrle_queue and pcxrle_back, and holds the configuration registers.
// Image data bytes arrive on the input channel (valid/stall), one byte per transfer, with a
// flag on the final byte. Pixel groups leave on the output channel, one group per transfer,
// tagged with column, line and end-of-line and end-of-image flags.
// The front end takes one byte per cycle while its four-entry command queue has room; a
// marker byte only updates the pending run length.
// The back end fetches a command, then stores each byte of its run in the line store and,
// when the byte completes a group, emits that group. Three-plane RGB and multi-plane 1-bit
// formats first read back the byte of each earlier plane, one at a time, from the single read
// port of the line store. A run is cut short at the end of a line, and dropped once the last
// line of the image is done.
// Each group is held in the output register while it is shown on the output.
// When the receiver stalls, the output register holds its group, the back end waits, and the
// queue fills until the input is stalled in turn.
// Reset clears the line position, line counter, pending marker and queue, and loads the
// configuration defaults; the line store is not cleared and needs no clearing pass.
module pcx_scanline_rle_decoder
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 8192
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    t_cmd w_q_data;
    logic w_q_full;
    logic w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compressed           <= 1'b1;
            r_cfg.plane_count          <= 3'd1;
            r_cfg.pixel_depth          <= 4'd8;
            r_cfg.bytes_per_plane_line <= 12'd1;
            r_cfg.image_width          <= 15'd1;
            r_cfg.image_height         <= 17'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COMPRESSED: begin
                    r_cfg.compressed <= i_cfg_data[0];
                end
                CFG_PLANE_COUNT: begin
                    r_cfg.plane_count <= i_cfg_data[2:0];
                end
                CFG_PIXEL_DEPTH: begin
                    r_cfg.pixel_depth <= i_cfg_data[3:0];
                end
                CFG_BYTES_PER_LINE: begin
                    r_cfg.bytes_per_plane_line <= i_cfg_data[11:0];
                end
                CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[14:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[16:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    pcxrle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_compressed (r_cfg.compressed),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    pcxrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    pcxrle_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_eoi_needs_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.end_of_line || !o_out_data.end_of_image))
        else $error("end of image flagged on a group that does not end its line");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pixel_count != 4'd0 && o_out_data.pixel_count <= 4'd8))
        else $error("pixel count of a group outside one to eight");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_q_full && i_in_valid))
        else $error("command pushed without an input transfer or into a full queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after a reset cycle");
`endif

endmodule
